/* design/bpra_pkg.sv */
// ---------------------------------------------------------------------------
// bpra_pkg: shared constants for the bitmap page run allocator
// Field widths, operation and status codes, configuration register indexes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

	localparam int MAX_PAGES_DEF  = 4096;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int ADDR_W   = 64;
	localparam int CNT_W    = 13;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_SPACE   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO_COUNT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_PAGES = 1'b1;

endpackage

`default_nettype wire

/* design/bpra_ram.sv */
// ---------------------------------------------------------------------------
// bpra_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpra_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/bitmap_page_run_allocator_core.sv */
// ---------------------------------------------------------------------------
// bitmap_page_run_allocator_core: first-fit contiguous page allocator
// Used-page bitmap in a word RAM; allocate scans for a free run, free clears.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries func, page_count, address.
//   Output channel (out_valid/out_ready) returns status and result_address,
//   one result per input transfer, in order.
//   cfg_we/cfg_index/cfg_data write heap_base (0) and heap_pages (1); write
//   only while no request is in flight.
// Operation:
//   allocate: scans up to ceil(heap size/64) bitmap words, then sets the
//   words touched by the run; a miss ends at the last heap word. The
//   scan reads one 64-bit word per cycle from the bitmap RAM.
//   free: one read-modify-write per word of the freed range.
//   Zero-count allocate or empty heap: no scan. Free with no heap page: no RMW.
// Reset: the bitmap RAM is cleared one word per cycle, with in_ready low;
//   config writes still land.
// Stall: one output register; a new request is taken while a result waits,
//   and the block holds its next result until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_run_allocator_core #(
	parameter int MAX_PAGES  = bpra_pkg::MAX_PAGES_DEF,
	parameter int PAGE_SHIFT = bpra_pkg::PAGE_SHIFT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bpra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bpra_pkg::ADDR_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              func,
	input  wire logic [bpra_pkg::CNT_W-1:0]        page_count,
	input  wire logic [bpra_pkg::ADDR_W-1:0]       address,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [bpra_pkg::STATUS_W-1:0]     status,
	output logic      [bpra_pkg::ADDR_W-1:0]       result_address
);
	import bpra_pkg::*;

	localparam int WORDS = (MAX_PAGES + 63) / 64;
	localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IW    = (WA + 7 > CNT_W + 1) ? WA + 7 : CNT_W + 1;
	localparam int DW    = ADDR_W - PAGE_SHIFT;

	localparam logic [IW-1:0] MAXP      = IW'(MAX_PAGES);
	localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FREE1 = 3'd2;
	localparam logic [2:0] S_FREE2 = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_HIT   = 3'd5;
	localparam logic [2:0] S_MARK  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   heap_base_q;
	logic [CNT_W-1:0]    heap_pages_q;

	logic [IW-1:0]       n_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [IW-1:0]       size_q;
	logic [DW-1:0]       d0_q;
	logic [WA-1:0]       clr_q;
	logic [WA-1:0]       rw_q;
	logic [WA-1:0]       lastw_q;
	logic                iss_q;
	logic                v_s1;
	logic [WA-1:0]       w_s1;
	logic [IW-1:0]       carry_q;
	logic [IW-1:0]       hitp_q;
	logic [IW-1:0]       lo_q;
	logic [IW-1:0]       hl_q;
	logic                set_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   result_address_q;

	logic                mem_we;
	logic [WA-1:0]       mem_waddr;
	logic [63:0]         mem_wdata;
	logic [WA-1:0]       mem_raddr;
	logic [63:0]         mem_rdata;

	bpra_ram #(
		.WIDTH(64),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// ---------------- request size ----------------
	logic [IW-1:0] size_c;
	logic [IW-1:0] size_m1_c;
	always_comb begin
		size_c    = (IW'(heap_pages_q) > MAXP) ? MAXP : IW'(heap_pages_q);
		size_m1_c = size_c - IW'(1);
	end

	// ---------------- scan word evaluation ----------------
	logic [63:0]   used_c;
	logic [63:0]   free_c;
	logic [IW-1:0] lim_c;
	logic [63:0]   lim_mask_c;
	logic [6:0]    tz_c;
	logic [5:0]    msb_c;
	logic          any_used_c;
	logic [IW:0]   tdiff_c;
	logic [IW-1:0] cp_c;
	logic          carry_ok_c;
	logic [63:0]   fw_c [7];
	logic [63:0]   win_c;
	logic [63:0]   rmask_c;
	logic [5:0]    wq_c;
	logic          w_hit_c;
	logic          hit_c;
	logic [5:0]    hit_pos_c;
	logic [IW-1:0] c_next_c;

	always_comb begin
		used_c     = mem_rdata;
		free_c     = ~mem_rdata;
		lim_c      = size_q - IW'({w_s1, 6'b0});
		lim_mask_c = (lim_c >= IW'(64)) ? {64{1'b1}} : ((64'd1 << lim_c[5:0]) - 64'd1);

		tz_c = 7'd64;
		for (int i = 63; i >= 0; i--) begin
			if (used_c[i]) tz_c = 7'(i);
		end
		msb_c = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (used_c[i]) msb_c = 6'(i);
		end
		any_used_c = |used_c;

		// run carried in from lower words: hit at bit max(n - carry - 1, 0)
		tdiff_c    = {1'b0, n_q} - {1'b0, carry_q} - (IW+1)'(1);
		cp_c       = tdiff_c[IW] ? '0 : tdiff_c[IW-1:0];
		carry_ok_c = (cp_c < IW'(tz_c)) && (cp_c < lim_c);

		// runs inside the word: windows of 2^j free bits, combined by bits of n
		fw_c[0] = free_c;
		for (int j = 1; j < 7; j++) begin
			fw_c[j] = fw_c[j-1] & (fw_c[j-1] << (1 << (j - 1)));
		end
		win_c = {64{1'b1}};
		for (int j = 0; j < 7; j++) begin
			if (n_q[j]) win_c = win_c & (fw_c[j] << (n_q[5:0] & 6'((1 << j) - 1)));
		end
		rmask_c = (n_q <= IW'(64)) ? (win_c & lim_mask_c) : 64'd0;
		w_hit_c = |rmask_c;
		wq_c    = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (rmask_c[i]) wq_c = 6'(i);
		end

		hit_c     = carry_ok_c || w_hit_c;
		hit_pos_c = (carry_ok_c && (!w_hit_c || cp_c[5:0] <= wq_c)) ? cp_c[5:0] : wq_c;
		c_next_c  = any_used_c ? IW'(6'd63 - msb_c) : carry_q + IW'(64);
	end

	// ---------------- free range ----------------
	logic [DW:0]   e_c;
	logic          in_range_c;
	logic          wrap_c;
	logic [DW:0]   end_src_c;
	logic [DW:0]   size_d_c;
	logic [IW-1:0] hi_ex_c;
	logic [IW-1:0] hl_f_c;
	logic [IW-1:0] lo_f_c;
	logic          free_go_c;

	always_comb begin
		size_d_c   = (DW+1)'(size_q);
		in_range_c = {1'b0, d0_q} < size_d_c;
		e_c        = {1'b0, d0_q} + (DW+1)'(n_q);
		// page indices wrap at most once, back to page zero
		wrap_c     = e_c[DW] && (|e_c[DW-1:0]);
		end_src_c  = in_range_c ? e_c : {1'b0, e_c[DW-1:0]};
		hi_ex_c    = (end_src_c < size_d_c) ? IW'(end_src_c) : size_q;
		hl_f_c     = hi_ex_c - IW'(1);
		lo_f_c     = in_range_c ? IW'(d0_q) : '0;
		free_go_c  = (in_range_c || wrap_c) && (hi_ex_c > lo_f_c);
	end

	// ---------------- alloc run ----------------
	logic [IW-1:0] run_lo_c;
	always_comb begin
		run_lo_c = hitp_q + IW'(1) - n_q;
	end

	// ---------------- bitmap write path ----------------
	logic [63:0] lower_m_c;
	logic [63:0] upper_m_c;
	logic [63:0] mark_m_c;
	always_comb begin
		lower_m_c = (w_s1 == lo_q[WA+5:6]) ? ({64{1'b1}} << lo_q[5:0]) : {64{1'b1}};
		upper_m_c = (w_s1 == hl_q[WA+5:6]) ? ({64{1'b1}} >> (6'd63 - hl_q[5:0]))
			: {64{1'b1}};
		mark_m_c  = lower_m_c & upper_m_c;

		mem_raddr = rw_q;
		mem_we    = (state_q == S_CLR) || ((state_q == S_MARK) && v_s1);
		mem_waddr = (state_q == S_CLR) ? clr_q : w_s1;
		if (state_q == S_CLR) begin
			mem_wdata = 64'd0;
		end else if (set_q) begin
			mem_wdata = mem_rdata | mark_m_c;
		end else begin
			mem_wdata = mem_rdata & ~mark_m_c;
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = result_address_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_pages_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEAP_BASE:  heap_base_q  <= cfg_data;
				CFG_HEAP_PAGES: heap_pages_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		w_s1 <= rw_q;
		unique case (state_q)
			S_IDLE: begin
				n_q    <= IW'(page_count);
				addr_q <= address;
				size_q <= size_c;
				if (func == FUNC_ALLOC) begin
					lastw_q <= size_m1_c[WA+5:6];
					carry_q <= '0;
					res_addr_q <= '0;
					res_status_q <= (page_count == '0) ? STAT_ZERO_COUNT : STAT_NO_SPACE;
				end else begin
					res_addr_q   <= '0;
					res_status_q <= STAT_OK;
				end
			end
			S_FREE1: begin
				d0_q <= DW'((addr_q - heap_base_q) >> PAGE_SHIFT);
			end
			S_FREE2: begin
				lo_q    <= lo_f_c;
				hl_q    <= hl_f_c;
				lastw_q <= hl_f_c[WA+5:6];
				set_q   <= 1'b0;
			end
			S_SCAN: begin
				if (v_s1) begin
					if (hit_c) begin
						hitp_q <= IW'({w_s1, hit_pos_c});
					end else begin
						carry_q <= c_next_c;
					end
				end
			end
			S_HIT: begin
				lo_q         <= run_lo_c;
				hl_q         <= hitp_q;
				lastw_q      <= hitp_q[WA+5:6];
				set_q        <= 1'b1;
				res_status_q <= STAT_OK;
				res_addr_q   <= heap_base_q + (ADDR_W'(run_lo_c) << PAGE_SHIFT);
			end
			default: ;
		endcase
		if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
			status_q         <= res_status_q;
			result_address_q <= res_addr_q;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rw_q        <= '0;
			iss_q       <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= iss_q;
			if (iss_q) begin
				rw_q <= rw_q + WA'(1);
				if (rw_q == lastw_q) iss_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + WA'(1);
					if (clr_q == LAST_WORD) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						if (func == FUNC_FREE) begin
							state_q <= S_FREE1;
						end else if ((page_count == '0) || (size_c == '0)) begin
							state_q <= S_DONE;
						end else begin
							rw_q    <= '0;
							iss_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_FREE1: state_q <= S_FREE2;
				S_FREE2: begin
					if (free_go_c) begin
						rw_q    <= lo_f_c[WA+5:6];
						iss_q   <= 1'b1;
						state_q <= S_MARK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (v_s1) begin
						if (hit_c) begin
							iss_q   <= 1'b0;
							state_q <= S_HIT;
						end else if (w_s1 == lastw_q) begin
							iss_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_HIT: begin
					rw_q    <= run_lo_c[WA+5:6];
					iss_q   <= 1'b1;
					state_q <= S_MARK;
				end
				S_MARK: begin
					if (v_s1 && (w_s1 == lastw_q)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- assertions ----------------
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !mem_we)
		else $error("bitmap written during scan");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != STAT_OK)) |-> (result_address_q == '0))
		else $error("failed request returned a nonzero address");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HIT) |=> ((hl_q - lo_q + IW'(1)) == n_q))
		else $error("marked run length differs from request");

	a_rmw_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == S_MARK)) |-> (mem_waddr == $past(mem_raddr)))
		else $error("write-back address differs from read address");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while busy");

endmodule

`default_nettype wire
